// ===== sv/otwm_pkg.sv =====
// Shared widths, constants and wheel weight table for the omni three-wheel mixer.
`default_nettype none

package otwm_pkg;

   localparam int HEADING_W = 9;
   localparam int SPEED_W   = 8;
   localparam int COR_W     = 8;
   localparam int DUTY_W    = 8;

   localparam int SECTORS  = 12;
   localparam int WHEELS   = 3;
   localparam int SECTOR_W = 4;
   localparam int WHEEL_W  = 2;

   // heading / 30 as (heading * 1093) >> 15, exact for every 9-bit heading
   localparam int SECTOR_RECIP  = 1093;
   localparam int SECTOR_SHIFT  = 15;
   localparam int SECTOR_PROD_W = 20;
   localparam int RAW_SECTOR_W  = 5;

   localparam int WEIGHT_W = 11;
   localparam int MAG_W    = 10;
   localparam int PROD_W   = 18;

   // x / 1000 as (x * 268436) >> 28, exact for x up to 255000
   localparam int DIV_RECIP   = 268436;
   localparam int DIV_RECIP_W = 19;
   localparam int DIV_SHIFT   = 28;
   localparam int DIV_PROD_W  = PROD_W + DIV_RECIP_W;

   localparam int QUO_W    = 8;
   localparam int QS_W     = QUO_W + 1;
   localparam int SUM_W    = 10;
   localparam int DUTY_MAX = 255;

   typedef logic [WHEEL_W-1:0] wheel_idx_type;

   localparam wheel_idx_type WHEEL_A = 2'd0;
   localparam wheel_idx_type WHEEL_B = 2'd1;
   localparam wheel_idx_type WHEEL_C = 2'd2;

   // sine/cosine weights scaled by 1000, one row per 30 degree sector
   localparam logic signed [WEIGHT_W-1:0] WEIGHTS [SECTORS][WHEELS] = '{
      '{ 11'sd866,  -11'sd866,  11'sd0    },
      '{ 11'sd1000, -11'sd500,  -11'sd500 },
      '{ 11'sd866,  11'sd0,     -11'sd866 },
      '{ 11'sd500,  11'sd500,   -11'sd1000},
      '{ 11'sd0,    11'sd866,   -11'sd866 },
      '{ -11'sd500, 11'sd1000,  -11'sd500 },
      '{ -11'sd866, 11'sd866,   11'sd0    },
      '{ -11'sd1000, 11'sd500,  11'sd500  },
      '{ -11'sd866, 11'sd0,     11'sd866  },
      '{ -11'sd500, -11'sd500,  11'sd1000 },
      '{ 11'sd0,    -11'sd866,  11'sd866  },
      '{ 11'sd500,  -11'sd1000, 11'sd500  }
   };

endpackage

`default_nettype wire

// ===== sv/otwm_channels.sv =====
// Valid/ready channel interfaces for drive commands and wheel results.
`default_nettype none

interface otwm_req_if;
   import otwm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [HEADING_W-1:0] heading_deg;
   logic [SPEED_W-1:0]   speed;
   logic signed [COR_W-1:0] turn_correction;

   modport source (output valid, heading_deg, speed, turn_correction, input ready);
   modport sink   (input valid, heading_deg, speed, turn_correction, output ready);
endinterface

interface otwm_rsp_if;
   import otwm_pkg::*;

   logic              valid;
   logic              ready;
   logic              wheel_a_reverse;
   logic [DUTY_W-1:0] wheel_a_duty;
   logic              wheel_b_reverse;
   logic [DUTY_W-1:0] wheel_b_duty;
   logic              wheel_c_reverse;
   logic [DUTY_W-1:0] wheel_c_duty;

   modport source (output valid, wheel_a_reverse, wheel_a_duty, wheel_b_reverse,
                   wheel_b_duty, wheel_c_reverse, wheel_c_duty, input ready);
   modport sink   (input valid, wheel_a_reverse, wheel_a_duty, wheel_b_reverse,
                   wheel_b_duty, wheel_c_reverse, wheel_c_duty, output ready);
endinterface

`default_nettype wire

// ===== sv/otwm_sector.sv =====
// Stage 1: heading to 30 degree sector index, inputs registered alongside.
`default_nettype none

module otwm_sector (
   input  wire logic                             clock,
   input  wire logic                             advance,
   input  wire logic [otwm_pkg::HEADING_W-1:0]   heading_deg,
   input  wire logic [otwm_pkg::SPEED_W-1:0]     speed,
   input  wire logic signed [otwm_pkg::COR_W-1:0] turn_correction,
   output logic [otwm_pkg::SECTOR_W-1:0]         sector,
   output logic [otwm_pkg::SPEED_W-1:0]          speed_q,
   output logic signed [otwm_pkg::COR_W-1:0]     cor_q
);
   import otwm_pkg::*;

   logic [SECTOR_PROD_W-1:0] recip_prod;
   logic [RAW_SECTOR_W-1:0]  raw_sector;
   logic [SECTOR_W-1:0]      sector_in, sector_ff;
   logic [SPEED_W-1:0]       speed_ff;
   logic signed [COR_W-1:0]  cor_ff;

   always_comb begin
      recip_prod = SECTOR_PROD_W'(heading_deg) * SECTOR_PROD_W'(SECTOR_RECIP);
      raw_sector = recip_prod[SECTOR_SHIFT +: RAW_SECTOR_W];
      // headings past 359 wrap once
      if (raw_sector >= RAW_SECTOR_W'(SECTORS)) begin
         sector_in = SECTOR_W'(raw_sector - RAW_SECTOR_W'(SECTORS));
      end else begin
         sector_in = SECTOR_W'(raw_sector);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sector_ff <= sector_in;
         speed_ff  <= speed;
         cor_ff    <= turn_correction;
      end
   end

   assign sector  = sector_ff;
   assign speed_q = speed_ff;
   assign cor_q   = cor_ff;

endmodule

`default_nettype wire

// ===== sv/otwm_wheel.sv =====
// Stages 2 and 3 for one wheel: weight times speed, then divide by 1000.
`default_nettype none

module otwm_wheel (
   input  wire logic                              clock,
   input  wire logic                              advance,
   input  wire otwm_pkg::wheel_idx_type           wheel,
   input  wire logic [otwm_pkg::SECTOR_W-1:0]     sector,
   input  wire logic [otwm_pkg::SPEED_W-1:0]      speed,
   input  wire logic signed [otwm_pkg::COR_W-1:0] cor,
   output logic signed [otwm_pkg::QS_W-1:0]       scaled,
   output logic signed [otwm_pkg::COR_W-1:0]      cor_q
);
   import otwm_pkg::*;

   logic signed [WEIGHT_W-1:0] weight;
   logic [WEIGHT_W-1:0]        weight_abs;
   logic [PROD_W-1:0]          prod_in, prod_ff;
   logic                       neg_ff;
   logic signed [COR_W-1:0]    cor2_ff, cor3_ff;
   logic [DIV_PROD_W-1:0]      div_prod;
   logic [QUO_W-1:0]           quo;
   logic signed [QS_W-1:0]     scaled_in, scaled_ff;

   // stage 2: sign and magnitude of the weight, unsigned product
   always_comb begin
      weight     = WEIGHTS[sector][wheel];
      weight_abs = weight[WEIGHT_W-1] ? WEIGHT_W'(-weight) : WEIGHT_W'(weight);
      prod_in    = PROD_W'(speed) * PROD_W'(weight_abs[MAG_W-1:0]);
   end

   // stage 3: magnitude divide, sign back on -> truncation toward zero
   always_comb begin
      div_prod  = DIV_PROD_W'(prod_ff) * DIV_PROD_W'(DIV_RECIP);
      quo       = div_prod[DIV_SHIFT +: QUO_W];
      scaled_in = neg_ff ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff   <= prod_in;
         neg_ff    <= weight[WEIGHT_W-1];
         cor2_ff   <= cor;
         scaled_ff <= scaled_in;
         cor3_ff   <= cor2_ff;
      end
   end

   assign scaled = scaled_ff;
   assign cor_q  = cor3_ff;

endmodule

`default_nettype wire

// ===== sv/otwm_drive.sv =====
// Stage 4 for one wheel: add correction, clamp to +-255, direction and duty.
`default_nettype none

module otwm_drive (
   input  wire logic                              clock,
   input  wire logic                              advance,
   input  wire logic signed [otwm_pkg::QS_W-1:0]  scaled,
   input  wire logic signed [otwm_pkg::COR_W-1:0] cor,
   output logic                                   reverse,
   output logic [otwm_pkg::DUTY_W-1:0]            duty
);
   import otwm_pkg::*;

   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(DUTY_MAX);
   localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX;

   logic signed [SUM_W-1:0] sum, clamped;
   logic [SUM_W-1:0]        mag;
   logic                    reverse_in, reverse_ff;
   logic [DUTY_W-1:0]       duty_in, duty_ff;

   always_comb begin
      sum = $signed({{(SUM_W-QS_W){scaled[QS_W-1]}}, scaled})
          + $signed({{(SUM_W-COR_W){cor[COR_W-1]}}, cor});
      if (sum > SUM_MAX) begin
         clamped = SUM_MAX;
      end else if (sum < SUM_MIN) begin
         clamped = SUM_MIN;
      end else begin
         clamped = sum;
      end
      reverse_in = clamped[SUM_W-1];
      mag        = reverse_in ? SUM_W'(-clamped) : SUM_W'(clamped);
      duty_in    = mag[DUTY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         reverse_ff <= reverse_in;
         duty_ff    <= duty_in;
      end
   end

   assign reverse = reverse_ff;
   assign duty    = duty_ff;

endmodule

`default_nettype wire

// ===== sv/omni_three_wheel_mixer_top.sv =====
// Top level of the omni three-wheel drive mixer: four-stage pipeline.
// A command accepted at one edge moves through the sector, product, quotient and result registers.
// Throughput: one command per cycle; the four stages advance together,
// so the rate is set by the output register being free or taken.
// A stalled result freezes every stage; nothing is dropped or repeated.
// Reset (synchronous, active high) clears the stage valid bits only.
`default_nettype none

module omni_three_wheel_mixer_top (
   input wire logic   clock,
   input wire logic   reset,
   otwm_req_if.sink   req_ch,
   otwm_rsp_if.source rsp_ch
);
   import otwm_pkg::*;

   // whole pipe moves when the output slot is empty or being taken
   logic advance;

   // valid bits: sector, product, quotient, result stages
   logic valid1_ff, valid2_ff, valid3_ff, valid4_ff;

   logic [SECTOR_W-1:0]     sector;
   logic [SPEED_W-1:0]      speed_q;
   logic signed [COR_W-1:0] cor_q;

   logic signed [QS_W-1:0]  scaled_a, scaled_b, scaled_c;
   logic signed [COR_W-1:0] cor_a, cor_b, cor_c;

   assign advance      = !valid4_ff || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign rsp_ch.valid = valid4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff <= req_ch.valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
      end
   end

   // stage 1: heading sector
   otwm_sector u_sector (
      .clock           (clock),
      .advance         (advance),
      .heading_deg     (req_ch.heading_deg),
      .speed           (req_ch.speed),
      .turn_correction (req_ch.turn_correction),
      .sector          (sector),
      .speed_q         (speed_q),
      .cor_q           (cor_q)
   );

   // stages 2-3: one scaler per wheel
   otwm_wheel u_wheel_a (
      .clock   (clock),
      .advance (advance),
      .wheel   (WHEEL_A),
      .sector  (sector),
      .speed   (speed_q),
      .cor     (cor_q),
      .scaled  (scaled_a),
      .cor_q   (cor_a)
   );

   otwm_wheel u_wheel_b (
      .clock   (clock),
      .advance (advance),
      .wheel   (WHEEL_B),
      .sector  (sector),
      .speed   (speed_q),
      .cor     (cor_q),
      .scaled  (scaled_b),
      .cor_q   (cor_b)
   );

   otwm_wheel u_wheel_c (
      .clock   (clock),
      .advance (advance),
      .wheel   (WHEEL_C),
      .sector  (sector),
      .speed   (speed_q),
      .cor     (cor_q),
      .scaled  (scaled_c),
      .cor_q   (cor_c)
   );

   // stage 4: clamp and output register
   otwm_drive u_drive_a (
      .clock   (clock),
      .advance (advance),
      .scaled  (scaled_a),
      .cor     (cor_a),
      .reverse (rsp_ch.wheel_a_reverse),
      .duty    (rsp_ch.wheel_a_duty)
   );

   otwm_drive u_drive_b (
      .clock   (clock),
      .advance (advance),
      .scaled  (scaled_b),
      .cor     (cor_b),
      .reverse (rsp_ch.wheel_b_reverse),
      .duty    (rsp_ch.wheel_b_duty)
   );

   otwm_drive u_drive_c (
      .clock   (clock),
      .advance (advance),
      .scaled  (scaled_c),
      .cor     (cor_c),
      .reverse (rsp_ch.wheel_c_reverse),
      .duty    (rsp_ch.wheel_c_duty)
   );

`ifndef ASSERT_OFF
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("input taken while result stalled");

   a_frozen_valids: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable({valid1_ff, valid2_ff, valid3_ff, valid4_ff}))
      else $error("stage valid changed during stall");

   a_stage1_from_accept: assert property (@(posedge clock) disable iff (reset)
      (valid1_ff && $past(advance)) |-> $past(req_ch.valid && req_ch.ready))
      else $error("stage 1 valid without accepted item");

   a_zero_duty_forward: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.wheel_a_duty == '0) |-> !rsp_ch.wheel_a_reverse)
      else $error("zero drive flagged reverse");
`endif

endmodule

`default_nettype wire
